FILE: design/lpit_pkg.sv
// Shared types and constants for the linear probe intern table.
package lpit_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int MAX_INPUTS_DEF = 4;
  localparam int NODE_ID_BITS   = 16;
  localparam int IN_FIELDS      = 4;
  localparam int HASH_BITS      = 64;
  localparam int TYPE_BITS      = 8;
  localparam int CNT_BITS       = 3;
  localparam int LOAD_NUM       = 3;
  localparam int LOAD_DEN       = 4;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_NULL = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_HOME    = 10'b00_0000_0010,
    S_PROBE   = 10'b00_0000_0100,
    S_CMP     = 10'b00_0000_1000,
    S_SCAN    = 10'b00_0001_0000,
    S_RH_CHK  = 10'b00_0010_0000,
    S_RH_READ = 10'b00_0100_0000,
    S_RH_HOME = 10'b00_1000_0000,
    S_RH_WALK = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [HASH_BITS-1:0] value;
  } home_req_t;

endpackage

FILE: design/lpit_slot_ram.sv
// Slot storage: one write port and one registered read port.
module lpit_slot_ram #(
  parameter int DEPTH = lpit_pkg::CAPACITY_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

FILE: design/lpit_home.sv
// Home slot unit: reduces a 64-bit hash modulo the table capacity.
module lpit_home #(
  parameter int CAPACITY = lpit_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpit_pkg::home_req_t         req,
  output logic                        done,
  output logic [$clog2(CAPACITY)-1:0] home
);

  localparam int AW = $clog2(CAPACITY);
  localparam int HB = lpit_pkg::HASH_BITS;

  if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
    // Power of two: the home slot is the low hash bits.
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= req.start;
      end
      if (req.start) begin
        home <= req.value[AW-1:0];
      end
    end
  end else begin : g_recip
    // Remainder by reciprocal multiplication, one 16-bit hash digit at a time, most
    // significant first, multiply then correct. The quotient estimate is at most one
    // low, so a single compare and subtract finishes each digit.
    localparam int     DB    = 16;
    localparam int     ND    = HB / DB;
    localparam int     VW    = AW + DB;
    localparam int     RW    = DB + 2;
    localparam longint RECIP = (longint'(1) << VW) / CAPACITY;

    logic [HB-1:0]         sh;
    logic [AW-1:0]         rem;
    logic [$clog2(ND)-1:0] digit;
    logic                  busy;
    logic                  phase;
    logic [VW-1:0]         v_r;
    logic [RW-1:0]         q_r;
    logic [VW-1:0]         v_in;
    logic [VW+RW-1:0]      prod;
    logic [VW-1:0]         t;

    assign v_in = {rem, sh[HB-1 -: DB]};
    assign prod = (VW+RW)'(v_in) * (VW+RW)'(RECIP);
    assign t    = v_r - VW'(q_r) * VW'(CAPACITY);
    assign home = rem;

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        done <= 1'b0;
      end else begin
        done <= 1'b0;
        if (req.start) begin
          busy  <= 1'b1;
          phase <= 1'b0;
          digit <= '0;
          sh    <= req.value;
          rem   <= '0;
        end else if (busy) begin
          if (!phase) begin
            v_r   <= v_in;
            q_r   <= prod[VW+RW-1:VW];
            sh    <= {sh[HB-DB-1:0], {DB{1'b0}}};
            phase <= 1'b1;
          end else begin
            if (t >= VW'(CAPACITY)) begin
              rem <= AW'(t - VW'(CAPACITY));
            end else begin
              rem <= AW'(t);
            end
            phase <= 1'b0;
            digit <= digit + 1'b1;
            if (digit == ($clog2(ND))'(ND - 1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

FILE: design/lpit_match.sv
// Key compare: hash, operation type, input count and the counted input ids.
module lpit_match #(
  parameter int ST_IN = lpit_pkg::MAX_INPUTS_DEF
) (
  input  logic [lpit_pkg::HASH_BITS-1:0]          e_hash,
  input  logic [lpit_pkg::TYPE_BITS-1:0]          e_type,
  input  logic [lpit_pkg::CNT_BITS-1:0]           e_cnt,
  input  logic [ST_IN*lpit_pkg::NODE_ID_BITS-1:0] e_ids,
  input  logic [lpit_pkg::HASH_BITS-1:0]          k_hash,
  input  logic [lpit_pkg::TYPE_BITS-1:0]          k_type,
  input  logic [lpit_pkg::CNT_BITS-1:0]           k_cnt,
  input  logic [ST_IN*lpit_pkg::NODE_ID_BITS-1:0] k_ids,
  output logic                                    hit
);

  localparam int IDW = lpit_pkg::NODE_ID_BITS;

  always_comb begin
    hit = (e_hash == k_hash) && (e_type == k_type) && (e_cnt == k_cnt);
    for (int i = 0; i < ST_IN; i++) begin
      if ((32'(k_cnt) > i) && (e_ids[i*IDW +: IDW] != k_ids[i*IDW +: IDW])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

FILE: design/linear_probe_intern_table.sv
// Top level of the linear probe intern table: sequencer, valid bits and count.
// Sequence: accept, home slot, then a probe and a compare per occupied slot until a hit or
// an empty slot, or one scan step per slot on insert, then the result. Remove re-places each
// following entry (check, read, home slot, walk to a hole or its own slot) until an empty slot.
// One beat at a time: a refused beat goes from accept straight to the result.
// Reset clears the valid bits and the entry count.
module linear_probe_intern_table #(
  parameter int CAPACITY   = lpit_pkg::CAPACITY_DEF,
  parameter int MAX_INPUTS = lpit_pkg::MAX_INPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] key_hash,
  input  logic [15:0] node_id,
  input  logic [7:0]  op_type,
  input  logic [2:0]  input_count,
  input  logic [15:0] input_id_0,
  input  logic [15:0] input_id_1,
  input  logic [15:0] input_id_2,
  input  logic [15:0] input_id_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] found_node,
  output logic [6:0]  entry_count
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDW   = lpit_pkg::NODE_ID_BITS;
  localparam int HB    = lpit_pkg::HASH_BITS;
  localparam int TB    = lpit_pkg::TYPE_BITS;
  localparam int NB    = lpit_pkg::CNT_BITS;
  // Ids past the fourth are never compared, so they are not stored.
  localparam int ST_IN = (MAX_INPUTS < lpit_pkg::IN_FIELDS) ? MAX_INPUTS
                                                            : lpit_pkg::IN_FIELDS;
  localparam int EW    = IDW + HB + TB + NB + ST_IN * IDW;
  localparam int LIMIT = CAPACITY * lpit_pkg::LOAD_NUM;

  function automatic logic [AW-1:0] step(input logic [AW-1:0] i);
    return (i == AW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  lpit_pkg::state_t state;

  // Latched key of the operation in progress.
  logic [1:0]          k_op;
  logic [HB-1:0]       k_hash;
  logic [IDW-1:0]      k_node;
  logic [TB-1:0]       k_type;
  logic [NB-1:0]       k_cnt;
  logic [ST_IN*IDW-1:0] k_ids;

  logic [CAPACITY-1:0] valid;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       nxt;
  logic [AW-1:0]       tgt;
  logic [1:0]          res_status;
  logic [IDW-1:0]      res_found;

  logic [lpit_pkg::IN_FIELDS*IDW-1:0] ids_all;
  logic [CW+2:0]       scaled;
  logic                full;
  logic                go_home;
  logic                walk_stop;

  logic                ram_we;
  logic [AW-1:0]       ram_wa;
  logic [EW-1:0]       ram_wd;
  logic                ram_re;
  logic [AW-1:0]       ram_ra;
  logic [EW-1:0]       rd_data;

  logic [IDW-1:0]      e_node;
  logic [HB-1:0]       e_hash;
  logic [TB-1:0]       e_type;
  logic [NB-1:0]       e_cnt;
  logic [ST_IN*IDW-1:0] e_ids;
  logic                hit;

  lpit_pkg::home_req_t home_req;
  logic                home_done;
  logic [AW-1:0]       home;

  assign ids_all = {input_id_3, input_id_2, input_id_1, input_id_0};

  // Insert is refused once the table reaches three quarters of its slots.
  assign scaled = (CW+3)'(count) * (CW+3)'(lpit_pkg::LOAD_DEN);
  assign full   = scaled >= (CW+3)'(LIMIT);

  // Field split of a stored entry.
  assign e_node = rd_data[EW-1 -: IDW];
  assign e_hash = rd_data[EW-IDW-1 -: HB];
  assign e_type = rd_data[EW-IDW-HB-1 -: TB];
  assign e_cnt  = rd_data[EW-IDW-HB-TB-1 -: NB];
  assign e_ids  = rd_data[ST_IN*IDW-1:0];

  // Decide at accept whether the operation needs to probe at all.
  always_comb begin
    case (op)
      lpit_pkg::OP_LOOKUP: go_home = (count != '0);
      lpit_pkg::OP_INSERT: go_home = (node_id != '0) && !full;
      lpit_pkg::OP_REMOVE: go_home = (node_id != '0) && (count != '0);
      default:             go_home = 1'b0;
    endcase
  end

  // An entry being re-placed stops at its own slot or the first hole.
  assign walk_stop = (tgt == nxt) || !valid[tgt];

  // The slot memory is read while probing or while re-placing a cluster, and is
  // written on insert or when a moved entry lands in a new slot. Reads and writes
  // never fall in the same cycle, and the read data holds during the walk.
  always_comb begin
    ram_re = ((state == lpit_pkg::S_PROBE) && valid[idx]) ||
             ((state == lpit_pkg::S_RH_CHK) && valid[nxt]);
    ram_ra = (state == lpit_pkg::S_PROBE) ? idx : nxt;
    ram_we = ((state == lpit_pkg::S_SCAN) && !valid[idx]) ||
             ((state == lpit_pkg::S_RH_WALK) && walk_stop && (tgt != nxt));
    ram_wa = (state == lpit_pkg::S_SCAN) ? idx : tgt;
    ram_wd = (state == lpit_pkg::S_SCAN) ? {k_node, k_hash, k_type, k_cnt, k_ids}
                                         : rd_data;
  end

  // The home unit is shared by the incoming key and by every re-placed entry.
  always_comb begin
    home_req.start = ((state == lpit_pkg::S_IDLE) && in_valid && go_home) ||
                     (state == lpit_pkg::S_RH_READ);
    home_req.value = (state == lpit_pkg::S_RH_READ) ? e_hash : key_hash;
  end

  assign in_stall = (state != lpit_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpit_pkg::S_IDLE;
      valid     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // The final state loads the next result beat itself.
      if (out_valid && !out_stall && (state != lpit_pkg::S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        lpit_pkg::S_IDLE: begin
          if (in_valid) begin
            k_op      <= op;
            k_hash    <= key_hash;
            k_node    <= node_id;
            k_type    <= op_type;
            k_cnt     <= input_count;
            k_ids     <= ids_all[ST_IN*IDW-1:0];
            res_found <= '0;
            if (go_home) begin
              res_status <= lpit_pkg::ST_MISS;
              state      <= lpit_pkg::S_HOME;
            end else begin
              if ((op == lpit_pkg::OP_INSERT || op == lpit_pkg::OP_REMOVE) &&
                  (node_id == '0)) begin
                res_status <= lpit_pkg::ST_NULL;
              end else if (op == lpit_pkg::OP_INSERT) begin
                res_status <= lpit_pkg::ST_FULL;
              end else begin
                res_status <= lpit_pkg::ST_MISS;
              end
              state <= lpit_pkg::S_FIN;
            end
          end
        end
        lpit_pkg::S_HOME: begin
          if (home_done) begin
            idx   <= home;
            state <= (k_op == lpit_pkg::OP_INSERT) ? lpit_pkg::S_SCAN : lpit_pkg::S_PROBE;
          end
        end
        lpit_pkg::S_PROBE: begin
          // An empty slot ends the cluster: the key is absent.
          state <= valid[idx] ? lpit_pkg::S_CMP : lpit_pkg::S_FIN;
        end
        lpit_pkg::S_CMP: begin
          if (k_op == lpit_pkg::OP_LOOKUP && hit) begin
            res_status <= lpit_pkg::ST_DONE;
            res_found  <= e_node;
            state      <= lpit_pkg::S_FIN;
          end else if (k_op == lpit_pkg::OP_REMOVE && e_node == k_node) begin
            valid[idx] <= 1'b0;
            count      <= count - 1'b1;
            nxt        <= step(idx);
            res_status <= lpit_pkg::ST_DONE;
            state      <= lpit_pkg::S_RH_CHK;
          end else begin
            idx   <= step(idx);
            state <= lpit_pkg::S_PROBE;
          end
        end
        lpit_pkg::S_SCAN: begin
          if (!valid[idx]) begin
            valid[idx] <= 1'b1;
            count      <= count + 1'b1;
            res_status <= lpit_pkg::ST_DONE;
            state      <= lpit_pkg::S_FIN;
          end else begin
            idx <= step(idx);
          end
        end
        lpit_pkg::S_RH_CHK: begin
          state <= valid[nxt] ? lpit_pkg::S_RH_READ : lpit_pkg::S_FIN;
        end
        lpit_pkg::S_RH_READ: begin
          state <= lpit_pkg::S_RH_HOME;
        end
        lpit_pkg::S_RH_HOME: begin
          if (home_done) begin
            tgt   <= home;
            state <= lpit_pkg::S_RH_WALK;
          end
        end
        lpit_pkg::S_RH_WALK: begin
          if (walk_stop) begin
            // A moved entry fills its new slot and empties its old one; an entry
            // that stays in place leaves the valid bits as they are.
            if (tgt != nxt) begin
              valid <= (valid | (CAPACITY'(1) << tgt)) & ~(CAPACITY'(1) << nxt);
            end
            nxt   <= step(nxt);
            state <= lpit_pkg::S_RH_CHK;
          end else begin
            tgt <= step(tgt);
          end
        end
        lpit_pkg::S_FIN: begin
          if (!out_valid || !out_stall) begin
            status      <= res_status;
            found_node  <= res_found;
            entry_count <= 7'(count);
            out_valid   <= 1'b1;
            state       <= lpit_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lpit_pkg::S_IDLE;
        end
      endcase
    end
  end

  lpit_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (rd_data)
  );

  lpit_home #(
    .CAPACITY (CAPACITY)
  ) u_home (
    .clk  (clk),
    .rst  (rst),
    .req  (home_req),
    .done (home_done),
    .home (home)
  );

  lpit_match #(
    .ST_IN (ST_IN)
  ) u_match (
    .e_hash (e_hash),
    .e_type (e_type),
    .e_cnt  (e_cnt),
    .e_ids  (e_ids),
    .k_hash (k_hash),
    .k_type (k_type),
    .k_cnt  (k_cnt),
    .k_ids  (k_ids),
    .hit    (hit)
  );

  // The entry count always equals the number of valid slots between operations.
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    (state == lpit_pkg::S_IDLE) |-> ($countones(valid) == 32'(count)))
    else $error("entry count differs from valid slots");

  // The insert scan runs only while a free slot exists.
  a_scan_free: assert property (@(posedge clk) disable iff (rst)
    (state == lpit_pkg::S_SCAN) |-> (~valid != '0))
    else $error("insert scan on a full table");

  // A nonzero found node is only reported with a hit.
  a_found_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_node != '0) |-> (status == lpit_pkg::ST_DONE))
    else $error("found node without hit");

  // An accepted beat always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != lpit_pkg::S_IDLE))
    else $error("accepted beat not started");

endmodule
